/* src/ntc_pkg.sv */
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared widths, register codes, status codes and bundle types for the NTC
// thermistor temperature core.
// ----------------------------------------------------------------------------
package ntc_pkg;

  // field widths
  localparam int SAMPLE_W     = 12;
  localparam int SAMPLE_BITS  = 12;
  localparam int SUPPLY_W     = 16;
  localparam int OHMS_W       = 20;
  localparam int BETA_W       = 14;
  localparam int CENTI_W      = 15;
  localparam int TEMP_W       = 16;
  localparam int LOG_FRAC_DEF = 16;

  // front end
  localparam int SUM_W     = OHMS_W + 1;
  localparam int DEN_W     = SAMPLE_BITS + SUM_W;
  localparam int SB_W      = SUPPLY_W + OHMS_W;
  localparam int NUM_SPLIT = 18;
  localparam int DEN_SPLIT = 17;
  localparam int PP_W      = OHMS_W + NUM_SPLIT;
  localparam int X_W       = OHMS_W + SB_W;

  // log unit
  localparam int GRP_W  = 8;
  localparam int NGRP   = X_W / GRP_W;
  localparam int GPOS_W = 3;
  localparam int MSB_W  = 6;
  localparam int MQ     = 30;
  localparam int M_W    = MQ + 1;
  localparam logic [MQ-1:0] LN2_Q30 = 30'd744261118;

  // temperature math
  localparam int CENTI_ZERO_C = 27315;
  localparam int K0_W         = 16;
  localparam int SBASE_W      = 21;
  localparam int BETA_SCALE   = 100;
  localparam int TB_W         = SBASE_W + K0_W;
  localparam int QUOT_W       = 17;
  localparam int TSUM_W       = QUOT_W + 2;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7FFF;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;

  // config port
  localparam int ADDR_W  = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_SUPPLY, REG_SERIES, REG_TOP, REG_BOTTOM,
    REG_NOMINAL, REG_BETA, REG_T0, REG_OFFSET
  } ntc_reg_t;

  typedef enum logic [1:0] {
    ST_OK, ST_ZERO, ST_NONPOS, ST_SAT
  } ntc_status_t;

  typedef struct packed {
    logic [SUPPLY_W-1:0] supply;
    logic [OHMS_W-1:0]   series;
    logic [OHMS_W-1:0]   top;
    logic [OHMS_W-1:0]   bottom;
    logic [OHMS_W-1:0]   nominal;
    logic [BETA_W-1:0]   beta;
    logic [CENTI_W-1:0]  t0;
    logic [CENTI_W-1:0]  offset;
  } ntc_cfg_t;

  // per-item control that rides along the datapath
  typedef struct packed {
    logic vld;
    logic zero;
    logic nonpos;
    logic tden_bad;
  } ntc_tag_t;

endpackage

/* src/ntc_front.sv */
// ----------------------------------------------------------------------------
// ntc_front
// Four-stage front end: divider ratio products, resistance numerator and
// denominator, then the two log arguments built from split multiplies.
// ----------------------------------------------------------------------------
module ntc_front import ntc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  logic [SAMPLE_W-1:0] sample,
  input  ntc_cfg_t            cfg,
  output ntc_tag_t            tag,
  output logic [X_W-1:0]      x1,
  output logic [X_W-1:0]      x2
);

  logic [SAMPLE_BITS-1:0] s_c;
  logic [SUM_W-1:0]       tb_c;
  logic [DEN_W-1:0]       den_c;
  logic [SB_W-1:0]        sb_c;

  ntc_tag_t         f1_tag, f2_tag, f3_tag;
  logic [DEN_W-1:0] f1_den, f2_den;
  logic [SB_W-1:0]  f1_sb, f2_num;
  logic [PP_W-1:0]  p1lo, p1hi, p2lo, p2hi;

  always_comb begin
    s_c   = sample[SAMPLE_BITS-1:0];
    tb_c  = SUM_W'(cfg.top) + SUM_W'(cfg.bottom);
    den_c = DEN_W'(s_c) * DEN_W'(tb_c);
    sb_c  = SB_W'(cfg.supply) * SB_W'(cfg.bottom);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_tag <= '0;
      f2_tag <= '0;
      f3_tag <= '0;
      tag    <= '0;
    end else if (en) begin
      f1_tag <= '{vld: in_vld, zero: (s_c == '0), nonpos: 1'b0, tden_bad: 1'b0};
      f2_tag <= '{vld: f1_tag.vld, zero: f1_tag.zero,
                  nonpos: (f1_sb <= SB_W'(f1_den)) || (cfg.series == '0) ||
                          (cfg.nominal == '0),
                  tden_bad: 1'b0};
      f3_tag <= f2_tag;
      tag    <= f3_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_den <= den_c;
      f1_sb  <= sb_c;
      f2_den <= f1_den;
      f2_num <= f1_sb - SB_W'(f1_den);
      // partial products keep each multiply near 20x18
      p1lo   <= PP_W'(cfg.series) * PP_W'(f2_num[NUM_SPLIT-1:0]);
      p1hi   <= PP_W'(cfg.series) * PP_W'(f2_num[SB_W-1:NUM_SPLIT]);
      p2lo   <= PP_W'(cfg.nominal) * PP_W'(f2_den[DEN_SPLIT-1:0]);
      p2hi   <= PP_W'(cfg.nominal) * PP_W'(f2_den[DEN_W-1:DEN_SPLIT]);
      x1     <= X_W'(p1lo) + (X_W'(p1hi) << NUM_SPLIT);
      x2     <= X_W'(p2lo) + (X_W'(p2hi) << DEN_SPLIT);
    end
  end

endmodule

/* src/ntc_log.sv */
// ----------------------------------------------------------------------------
// ntc_log
// Pipelined natural log, Q(FRAC_BITS): leading-one search in two stages,
// normalize to Q30, one squaring stage per fraction bit, scale by ln2.
// ----------------------------------------------------------------------------
module ntc_log import ntc_pkg::*; #(
  parameter int FRAC_BITS = LOG_FRAC_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [X_W-1:0]               x,
  output logic [MSB_W+FRAC_BITS-1:0]   ln
);

  localparam int L2_W   = MSB_W + FRAC_BITS;
  localparam int PROD_W = L2_W + MQ;

  logic [NGRP-1:0]   nz_c, a_nz;
  logic [GPOS_W-1:0] pos_c [NGRP];
  logic [GPOS_W-1:0] a_pos [NGRP];
  logic [X_W-1:0]    a_x, b_x;
  logic [MSB_W-1:0]  msb_c, b_msb;
  logic [X_W+MQ-1:0] sh_c;

  logic [M_W-1:0]       sq_m    [0:FRAC_BITS];
  logic [MSB_W-1:0]     sq_msb  [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] sq_frac [0:FRAC_BITS];

  logic [PROD_W-1:0] m_prod, rnd_c;

  // per-byte leading one
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      nz_c[g]  = |x[g*GRP_W +: GRP_W];
      pos_c[g] = '0;
      for (int b = 0; b < GRP_W; b++) begin
        if (x[g*GRP_W + b]) pos_c[g] = GPOS_W'(b);
      end
    end
  end

  always_comb begin
    msb_c = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (a_nz[g]) msb_c = MSB_W'(g * GRP_W) | MSB_W'(a_pos[g]);
    end
  end

  assign sh_c = {b_x, {MQ{1'b0}}} >> b_msb;

  always_ff @(posedge clk) begin
    if (en) begin
      a_x        <= x;
      a_nz       <= nz_c;
      a_pos      <= pos_c;
      b_x        <= a_x;
      b_msb      <= msb_c;
      sq_m[0]    <= sh_c[M_W-1:0];
      sq_msb[0]  <= b_msb;
      sq_frac[0] <= '0;
    end
  end

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_sq
    logic [2*M_W-1:0] p;
    logic [M_W:0]     t;

    always_comb begin
      p = (2*M_W)'(sq_m[i]) * (2*M_W)'(sq_m[i]);
      t = p[MQ+M_W:MQ];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_m[i+1]    <= t[M_W] ? t[M_W:1] : t[M_W-1:0];
        sq_frac[i+1] <= {sq_frac[i][FRAC_BITS-2:0], t[M_W]};
        sq_msb[i+1]  <= sq_msb[i];
      end
    end
  end

  assign rnd_c = m_prod + (PROD_W'(1) << (MQ - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      m_prod <= PROD_W'({sq_msb[FRAC_BITS], sq_frac[FRAC_BITS]}) * PROD_W'(LN2_Q30);
      ln     <= rnd_c[PROD_W-1:MQ];
    end
  end

endmodule

/* src/ntc_div.sv */
// ----------------------------------------------------------------------------
// ntc_div
// Restoring divider, one quotient bit per stage, with a range check up
// front: quotients at or above 2^QUOT_W only flag overflow.
// ----------------------------------------------------------------------------
module ntc_div import ntc_pkg::*; #(
  parameter int NUMER_W = 54,
  parameter int UD_W    = 39
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  ntc_tag_t           tag_in,
  input  logic [NUMER_W-1:0] numer,
  input  logic [UD_W-1:0]    ud,
  output ntc_tag_t           tag_out,
  output logic               ovf,
  output logic [QUOT_W-1:0]  quot
);

  localparam int CMP_W = UD_W + QUOT_W + 1;

  ntc_tag_t           d_tag [0:QUOT_W-1];
  logic               d_ovf [0:QUOT_W-1];
  logic [NUMER_W-1:0] d_rem [0:QUOT_W-1];
  logic [UD_W-1:0]    d_ud  [0:QUOT_W-1];
  logic [QUOT_W-1:0]  d_q   [0:QUOT_W-1];

  always_ff @(posedge clk) begin
    if (rst) d_tag[0] <= '0;
    else if (en) d_tag[0] <= tag_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_ovf[0] <= CMP_W'(numer) >= (CMP_W'(ud) << QUOT_W);
      d_rem[0] <= numer;
      d_ud[0]  <= ud;
      d_q[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= QUOT_W; k++) begin : g_bit
    localparam int B = QUOT_W - k;
    logic [CMP_W-1:0] trial;
    logic             take;

    always_comb begin
      trial = CMP_W'(d_ud[k-1]) << B;
      take  = CMP_W'(d_rem[k-1]) >= trial;
    end

    if (k < QUOT_W) begin : g_mid
      always_ff @(posedge clk) begin
        if (rst) d_tag[k] <= '0;
        else if (en) d_tag[k] <= d_tag[k-1];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          d_ovf[k] <= d_ovf[k-1];
          d_ud[k]  <= d_ud[k-1];
          d_rem[k] <= take ? d_rem[k-1] - trial[NUMER_W-1:0] : d_rem[k-1];
          d_q[k]   <= d_q[k-1] | (QUOT_W'(take) << B);
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (rst) tag_out <= '0;
        else if (en) tag_out <= d_tag[k-1];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          ovf  <= d_ovf[k-1];
          quot <= d_q[k-1] | (QUOT_W'(take) << B);
        end
      end
    end
  end

endmodule

/* src/ntc_beta_thermistor_temp_core.sv */
// ----------------------------------------------------------------------------
// ntc_beta_thermistor_temp_core
// NTC thermistor temperature from one ADC sample via the beta equation.
// ----------------------------------------------------------------------------
// Each sample_mv item yields one result item: temp_centi in signed hundredths
// of a degree C and a status (ok, zero sample, non-positive resistance,
// saturated). The sample is scaled back through the second divider, the
// thermistor resistance is formed as an exact ratio, ln(R/R0) is taken with
// two pipelined Q(LOG_FRAC_BITS) log units, and T = B*T0/(T0*ln + B) is
// finished with a pipelined restoring divider. The pipeline takes one item
// every cycle; most of its depth comes from the squaring stages of the log
// units (one per fraction bit) and the 17 quotient-bit stages of the divider.
// An output register plus a skid register decouple result_ready from
// sample_ready: when the skid register fills, the whole pipeline holds.
// Configuration sits on an APB-style port, register i at byte address 4*i;
// write only while no item is in flight.
// ----------------------------------------------------------------------------
module ntc_beta_thermistor_temp_core import ntc_pkg::*; #(
  parameter int LOG_FRAC_BITS = LOG_FRAC_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // sample channel
  input  logic                     sample_valid,
  output logic                     sample_ready,
  input  logic [SAMPLE_W-1:0]      sample_mv,
  // result channel
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic signed [TEMP_W-1:0] temp_centi,
  output logic [1:0]               status,
  // config port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  localparam int F       = LOG_FRAC_BITS;
  localparam int L2_W    = MSB_W + F;
  localparam int LNQ_W   = L2_W + 1;
  localparam int PRD_W   = LNQ_W + K0_W;
  localparam int TD_W    = PRD_W + 1;
  localparam int UD_W    = TD_W - 1;
  localparam int TN_W    = TB_W + F;
  localparam int NUMER_W = TN_W + 1;
  localparam int LOG_LAT = F + 5;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  ntc_cfg_t cfg;
  ntc_reg_t widx;
  logic     wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign widx   = ntc_reg_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.supply  <= SUPPLY_W'(12000);
      cfg.series  <= OHMS_W'(10000);
      cfg.top     <= OHMS_W'(30000);
      cfg.bottom  <= OHMS_W'(10000);
      cfg.nominal <= OHMS_W'(10000);
      cfg.beta    <= BETA_W'(3950);
      cfg.t0      <= CENTI_W'(2500);
      cfg.offset  <= '0;
    end else if (wr) begin
      case (widx)
        REG_SUPPLY:  cfg.supply  <= pwdata[SUPPLY_W-1:0];
        REG_SERIES:  cfg.series  <= pwdata[OHMS_W-1:0];
        REG_TOP:     cfg.top     <= pwdata[OHMS_W-1:0];
        REG_BOTTOM:  cfg.bottom  <= pwdata[OHMS_W-1:0];
        REG_NOMINAL: cfg.nominal <= pwdata[OHMS_W-1:0];
        REG_BETA:    cfg.beta    <= pwdata[BETA_W-1:0];
        REG_T0:      cfg.t0      <= pwdata[CENTI_W-1:0];
        REG_OFFSET:  cfg.offset  <= pwdata[CENTI_W-1:0];
        default: ;
      endcase
    end
  end

  // signed registers read back sign-extended
  always_comb begin
    case (widx)
      REG_SUPPLY:  prdata = PDATA_W'(cfg.supply);
      REG_SERIES:  prdata = PDATA_W'(cfg.series);
      REG_TOP:     prdata = PDATA_W'(cfg.top);
      REG_BOTTOM:  prdata = PDATA_W'(cfg.bottom);
      REG_NOMINAL: prdata = PDATA_W'(cfg.nominal);
      REG_BETA:    prdata = PDATA_W'(cfg.beta);
      REG_T0:      prdata = PDATA_W'($signed(cfg.t0));
      REG_OFFSET:  prdata = PDATA_W'($signed(cfg.offset));
      default:     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline enable: the whole datapath advances unless the skid is full
  // --------------------------------------------------------------------------
  logic en;
  logic skid_valid;

  assign en           = !skid_valid;
  assign sample_ready = en;

  // --------------------------------------------------------------------------
  // Front end: 4 stages to the two log arguments
  // --------------------------------------------------------------------------
  ntc_tag_t       fe_tag;
  logic [X_W-1:0] fe_x1, fe_x2;

  ntc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (sample_valid),
    .sample (sample_mv),
    .cfg    (cfg),
    .tag    (fe_tag),
    .x1     (fe_x1),
    .x2     (fe_x2)
  );

  // --------------------------------------------------------------------------
  // Logs: ln(series*num) and ln(den*nominal), tag delayed to match
  // --------------------------------------------------------------------------
  logic [L2_W-1:0] ln1, ln2;
  ntc_tag_t        lg_tag [0:LOG_LAT-1];

  ntc_log #(.FRAC_BITS(F)) u_log_num (.clk(clk), .en(en), .x(fe_x1), .ln(ln1));
  ntc_log #(.FRAC_BITS(F)) u_log_den (.clk(clk), .en(en), .x(fe_x2), .ln(ln2));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < LOG_LAT; j++) lg_tag[j] <= '0;
    end else if (en) begin
      lg_tag[0] <= fe_tag;
      for (int j = 1; j < LOG_LAT; j++) lg_tag[j] <= lg_tag[j-1];
    end
  end

  // --------------------------------------------------------------------------
  // Beta equation: T1 ln difference and config terms, T2 products,
  // T3 denominator and numerator, T4 rounding bias for the divide
  // --------------------------------------------------------------------------
  logic [BETA_W-1:0]        beta_c;
  logic signed [K0_W:0]     k0_s;
  ntc_tag_t                 t1_tag, t2_tag, t3_tag, t4_tag;
  logic signed [LNQ_W-1:0]  t1_lnq;
  logic [K0_W-1:0]          t1_k0;
  logic [SBASE_W-1:0]       t1_sbase, t2_sbase;
  logic signed [PRD_W-1:0]  t2_prod;
  logic [TB_W-1:0]          t2_tnb;
  logic signed [TD_W-1:0]   t3_tden, scale_s;
  logic [TN_W-1:0]          t3_tnum;
  logic [NUMER_W-1:0]       t4_numer;
  logic [UD_W-1:0]          t4_ud, ud_c;
  logic                     tden_bad_c;

  always_comb begin
    beta_c     = (cfg.beta == '0) ? BETA_W'(1) : cfg.beta;
    // T0 in centikelvin; always positive for any 15-bit T0
    k0_s       = $signed({{2{cfg.t0[CENTI_W-1]}}, cfg.t0}) + (K0_W+1)'(CENTI_ZERO_C);
    scale_s    = $signed({{(TD_W-SBASE_W-F){1'b0}}, t2_sbase, {F{1'b0}}});
    tden_bad_c = t3_tden[TD_W-1] || (t3_tden == '0);
    ud_c       = t3_tden[UD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_tag <= '0;
      t2_tag <= '0;
      t3_tag <= '0;
      t4_tag <= '0;
    end else if (en) begin
      t1_tag <= lg_tag[LOG_LAT-1];
      t2_tag <= t1_tag;
      t3_tag <= t2_tag;
      t4_tag <= '{vld: t3_tag.vld, zero: t3_tag.zero, nonpos: t3_tag.nonpos,
                  tden_bad: tden_bad_c};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_lnq   <= $signed(LNQ_W'(ln1)) - $signed(LNQ_W'(ln2));
      t1_k0    <= k0_s[K0_W-1:0];
      t1_sbase <= SBASE_W'(beta_c) * SBASE_W'(BETA_SCALE);
      t2_prod  <= PRD_W'(t1_lnq) * $signed({{(PRD_W-K0_W){1'b0}}, t1_k0});
      t2_tnb   <= TB_W'(t1_sbase) * TB_W'(t1_k0);
      t2_sbase <= t1_sbase;
      t3_tden  <= TD_W'(t2_prod) + scale_s;
      t3_tnum  <= {t2_tnb, {F{1'b0}}};
      t4_ud    <= ud_c;
      t4_numer <= NUMER_W'(t3_tnum) + NUMER_W'(ud_c >> 1);
    end
  end

  // --------------------------------------------------------------------------
  // Divide: T in centikelvin, rounded half up
  // --------------------------------------------------------------------------
  ntc_tag_t          dv_tag;
  logic              dv_ovf;
  logic [QUOT_W-1:0] dv_quot;

  ntc_div #(.NUMER_W(NUMER_W), .UD_W(UD_W)) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tag_in  (t4_tag),
    .numer   (t4_numer),
    .ud      (t4_ud),
    .tag_out (dv_tag),
    .ovf     (dv_ovf),
    .quot    (dv_quot)
  );

  // --------------------------------------------------------------------------
  // Finish: to Celsius, add offset, saturate, pick status
  // --------------------------------------------------------------------------
  logic signed [TSUM_W-1:0] tsum_c;
  logic signed [TEMP_W-1:0] p_temp;
  ntc_status_t              p_stat;
  logic                     push;

  always_comb begin
    tsum_c = $signed({2'b00, dv_quot}) - TSUM_W'(CENTI_ZERO_C) +
             TSUM_W'($signed(cfg.offset));
    if (dv_tag.zero) begin
      p_temp = '0;
      p_stat = ST_ZERO;
    end else if (dv_tag.nonpos) begin
      p_temp = '0;
      p_stat = ST_NONPOS;
    end else if (dv_tag.tden_bad || dv_ovf) begin
      // infinite or very large temperature
      p_temp = TEMP_MAX;
      p_stat = ST_SAT;
    end else if (tsum_c > TSUM_W'(TEMP_MAX)) begin
      p_temp = TEMP_MAX;
      p_stat = ST_SAT;
    end else if (tsum_c < TSUM_W'(TEMP_MIN)) begin
      p_temp = TEMP_MIN;
      p_stat = ST_SAT;
    end else begin
      p_temp = tsum_c[TEMP_W-1:0];
      p_stat = ST_OK;
    end
  end

  assign push = en && dv_tag.vld;

  // --------------------------------------------------------------------------
  // Output register and skid register
  // --------------------------------------------------------------------------
  logic signed [TEMP_W-1:0] res_temp, skid_temp;
  ntc_status_t              res_stat, skid_stat;
  logic                     take;

  assign take = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (take) skid_valid <= 1'b0;
    end else if (push) begin
      if (result_valid && !take) skid_valid <= 1'b1;
      else result_valid <= 1'b1;
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        res_temp <= skid_temp;
        res_stat <= skid_stat;
      end
    end else if (push) begin
      if (result_valid && !take) begin
        skid_temp <= p_temp;
        skid_stat <= p_stat;
      end else begin
        res_temp <= p_temp;
        res_stat <= p_stat;
      end
    end
  end

  assign temp_centi = res_temp;
  assign status     = res_stat;

`ifndef SYNTHESIS
  // the skid register only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid holds an item while output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(result_valid && !result_ready))
    else $error("skid filled without an output stall");

  a_zero_temp: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_ZERO || status == ST_NONPOS) |-> temp_centi == '0)
    else $error("error status with nonzero temperature");
`endif

endmodule
